>>> design/vsd_pkg.sv
// Shared types and constants for the VADPCM sample decoder.
`timescale 1ns / 1ps
package vsd_pkg;
    localparam int BOOK_ENTRIES = 512;
    localparam int AW = $clog2(BOOK_ENTRIES);
    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 4;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_BYTE    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_ORDER = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    localparam logic [23:0] LIMIT_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]             kind;
        logic [AW-1:0]          base;
        logic [2:0]             first;
        logic                   mode;
        logic                   upd;
        logic [3:0][15:0]       res;
    } t_cmd;

    typedef struct packed {
        logic        mode;
        logic [2:0]  order;
        logic [23:0] limit;
    } t_cfg;
endpackage

>>> design/vsd_front.sv
// Front end: frame parsing, residual expansion and command generation.
`timescale 1ns / 1ps
module vsd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_kind,
    input  logic [8:0]         i_book_index,
    input  logic signed [15:0] i_book_value,
    input  logic [7:0]         i_data_byte,
    input  vsd_pkg::t_cfg      i_cfg,
    output logic               o_cmd_valid,
    output vsd_pkg::t_cmd      o_cmd
);
    import vsd_pkg::*;

    logic [3:0] r_shift, n_shift;
    logic [3:0] r_pred, n_pred;
    logic [3:0] r_pos, n_pos;

    logic [3:0]  flen;
    logic [3:0]  pm1;
    logic [1:0]  idx;
    logic        is_header;
    logic [9:0]  base_full;
    logic [6:0]  po;
    logic [15:0] code [4];

    always_comb begin
        flen = i_cfg.mode ? 4'd5 : 4'd9;
        pm1 = r_pos - 4'd1;
        idx = i_cfg.mode ? {1'b0, pm1[0]} : pm1[1:0];
        is_header = (r_pos == 4'd0) || (r_pos >= flen);
        po = 7'(r_pred * i_cfg.order);
        base_full = {po, 3'b000};
        if (i_cfg.mode) begin
            code[0] = {{14{i_data_byte[7]}}, i_data_byte[7:6]};
            code[1] = {{14{i_data_byte[5]}}, i_data_byte[5:4]};
            code[2] = {{14{i_data_byte[3]}}, i_data_byte[3:2]};
            code[3] = {{14{i_data_byte[1]}}, i_data_byte[1:0]};
        end else begin
            code[0] = {{12{i_data_byte[7]}}, i_data_byte[7:4]};
            code[1] = {{12{i_data_byte[3]}}, i_data_byte[3:0]};
            code[2] = 16'd0;
            code[3] = 16'd0;
        end

        n_shift = r_shift;
        n_pred = r_pred;
        n_pos = r_pos;
        o_cmd_valid = 1'b0;
        o_cmd.kind = i_kind;
        o_cmd.base = AW'(base_full);
        o_cmd.first = i_cfg.mode ? {idx[0], 2'b00} : {idx, 1'b0};
        o_cmd.mode = i_cfg.mode;
        o_cmd.upd = i_cfg.mode ? (idx == 2'd1) : (idx == 2'd3);
        for (int j = 0; j < 4; j++) begin
            o_cmd.res[j] = code[j] << r_shift;
        end
        if (i_accept) begin
            unique case (i_kind)
                KIND_LOAD: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.base = AW'(i_book_index);
                    o_cmd.res[0] = i_book_value;
                end
                KIND_RESTART: begin
                    o_cmd_valid = 1'b1;
                    n_shift = 4'd0;
                    n_pred = 4'd0;
                    n_pos = 4'd0;
                end
                KIND_BYTE: begin
                    if (is_header) begin
                        n_shift = i_data_byte[7:4];
                        n_pred = i_data_byte[3:0];
                        n_pos = 4'd1;
                    end else begin
                        o_cmd_valid = 1'b1;
                        n_pos = (r_pos + 4'd1 >= flen) ? 4'd0 : r_pos + 4'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 4'd0;
            r_pred <= 4'd0;
            r_pos <= 4'd0;
        end else begin
            r_shift <= n_shift;
            r_pred <= n_pred;
            r_pos <= n_pos;
        end
    end
endmodule

>>> design/vsd_cmdq.sv
// Short command queue between the front end and the decode engine.
`timescale 1ns / 1ps
module vsd_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  vsd_pkg::t_cmd i_wdata,
    input  logic          i_rd,
    output logic          o_full,
    output logic          o_valid,
    output vsd_pkg::t_cmd o_rdata
);
    import vsd_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);

    t_cmd r_mem [CMDQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0] r_cnt;

    assign o_full = (r_cnt == (PW+1)'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= (r_rp == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_wr) - (PW+1)'(i_rd);
        end
    end
endmodule

>>> design/vsd_back.sv
// Decode engine: codebook memory, shared multiply-accumulate and result queue.
`timescale 1ns / 1ps
module vsd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vsd_pkg::t_cfg      i_cfg,
    input  logic               i_cmd_valid,
    input  vsd_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic signed [15:0] o_pcm_sample,
    output logic               o_last
);
    import vsd_pkg::*;

    localparam int OW = $clog2(OUTQ_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic signed [15:0] r_book [BOOK_ENTRIES];
    logic signed [15:0] r_res [8];
    logic [1:0]  r_state;
    t_cmd        r_cmd;
    logic [1:0]  r_j;
    logic [3:0]  r_k;
    logic signed [15:0] r_coef, r_opnd;
    logic signed [31:0] r_prod, r_acc;
    logic        r_v1, r_l1, r_v2, r_l2, r_done;
    logic signed [15:0] r_old, r_new, r_prev;
    logic [23:0] r_cnt;

    logic [17:0]   r_oq [OUTQ_DEPTH];
    logic [OW-1:0] r_owp, r_orp;
    logic [OW:0]   r_ocnt;

    logic [2:0]  smp_i;
    logic        last_term;
    logic [3:0]  off;
    logic [AW-1:0] rd_addr;
    logic [2:0]  res_sel;
    logic signed [15:0] res_rd, opnd;
    logic        room, issue;
    logic signed [20:0] shr;
    logic signed [15:0] smp;
    logic        last_j, emit, is_last, opush, opop;
    logic [23:0] cnt_inc;
    logic        wr_book;

    always_comb begin
        smp_i = r_cmd.first + 3'(r_j);
        last_term = (r_k == {1'b0, smp_i} + 4'd1);
        if (r_k == 4'd0) begin
            off = {1'b0, smp_i};
        end else if (r_k == 4'd1) begin
            off = 4'd8 + {1'b0, smp_i};
        end else begin
            off = 4'd8 + {1'b0, smp_i} + 4'd1 - r_k + 4'd2 - 4'd2;
        end
        rd_addr = r_cmd.base + AW'(off);
        res_sel = (r_k == 4'd1) ? smp_i : 3'(r_k - 4'd2);
        res_rd = r_res[res_sel];
        opnd = (r_k == 4'd0) ? r_old : ((r_k == 4'd1) ? r_new : res_rd);
        room = (r_ocnt != (OW+1)'(OUTQ_DEPTH));
        issue = (r_state == S_ISSUE) && ((r_k != 4'd0) || room);
        o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
        wr_book = o_cmd_pop && (i_cmd.kind == KIND_LOAD);

        shr = 21'(r_acc >>> 11);
        if (shr > 21'sd32767) begin
            smp = 16'sd32767;
        end else if (shr < -21'sd32768) begin
            smp = -16'sd32768;
        end else begin
            smp = shr[15:0];
        end
        last_j = r_cmd.mode ? (r_j == 2'd3) : (r_j == 2'd1);
        emit = (i_cfg.limit == 24'd0) || (r_cnt < i_cfg.limit);
        cnt_inc = (r_cnt < LIMIT_MAX) ? r_cnt + 24'd1 : r_cnt;
        is_last = last_j || ((i_cfg.limit != 24'd0) && (r_cnt + 24'd1 >= i_cfg.limit));
        opush = r_done && (r_state == S_DRAIN) && emit;
        opop = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (wr_book) begin
            r_book[i_cmd.base] <= i_cmd.res[0];
        end
        r_coef <= r_book[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.kind == KIND_BYTE)) begin
            r_cmd <= i_cmd;
            for (int j = 0; j < 4; j++) begin
                if (i_cmd.mode || (j < 2)) begin
                    r_res[i_cmd.first + 3'(j)] <= i_cmd.res[j];
                end
            end
        end
        if (issue) begin
            r_opnd <= opnd;
        end
        if (r_v1) begin
            r_prod <= r_coef * r_opnd;
        end
        if (issue && (r_k == 4'd1)) begin
            r_acc <= 32'(res_rd) <<< 11;
        end else if (r_v2) begin
            r_acc <= r_acc + r_prod;
        end
        if (opush) begin
            r_oq[r_owp] <= {is_last, smp, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j <= 2'd0;
            r_k <= 4'd0;
            r_v1 <= 1'b0;
            r_l1 <= 1'b0;
            r_v2 <= 1'b0;
            r_l2 <= 1'b0;
            r_done <= 1'b0;
            r_old <= 16'sd0;
            r_new <= 16'sd0;
            r_prev <= 16'sd0;
            r_cnt <= 24'd0;
            r_owp <= '0;
            r_orp <= '0;
            r_ocnt <= '0;
        end else begin
            r_v1 <= issue;
            r_l1 <= issue && last_term;
            r_v2 <= r_v1;
            r_l2 <= r_l1;
            r_done <= r_v2 && r_l2;
            if (opush) begin
                r_owp <= r_owp + 1'b1;
            end
            if (opop) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= r_ocnt + (OW+1)'(opush) - (OW+1)'(opop);
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.kind == KIND_RESTART) begin
                            r_old <= 16'sd0;
                            r_new <= 16'sd0;
                            r_cnt <= 24'd0;
                        end else if (i_cmd.kind == KIND_BYTE) begin
                            r_j <= 2'd0;
                            r_k <= 4'd0;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    if (issue) begin
                        r_k <= r_k + 4'd1;
                        if (last_term) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (r_done) begin
                        r_prev <= smp;
                        if (emit) begin
                            r_cnt <= cnt_inc;
                        end
                        r_k <= 4'd0;
                        if (last_j) begin
                            if (r_cmd.upd) begin
                                r_old <= r_prev;
                                r_new <= smp;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_j <= r_j + 2'd1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_empty = (r_ocnt == '0);
    assign o_pcm_sample = r_oq[r_orp][16:1];
    assign o_last = r_oq[r_orp][17] | r_oq[r_orp][0];
endmodule

>>> design/vadpcm_sample_decoder_top.sv
// Top level of the VADPCM sample decoder with its configuration registers.
//
//   Channel   Direction  Handshake            Fields
//   input     in         push / full          kind, book_index, book_value, data_byte
//   result    out        pop / empty          pcm_sample, last
//   config    in         APB psel / penable   codec_mode, book_order, sample_limit
//
// A data byte with residuals leaves the command queue in the engine's idle state, then,
// per sample i of its half, takes i + 2 products on the single codebook read port and
// multiplier, followed by a drain through the product and accumulator registers.
// Loads and restarts are handled in the engine's idle state; headers stay in the front end.
// The two-entry command queue lets the input side go on while the engine is busy.
// The engine pauses before a sample while the four-entry result queue is full.
// Reset is synchronous; the codebook has no clearing pass.
`timescale 1ns / 1ps
module vadpcm_sample_decoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_kind,
    input  logic [8:0]         i_book_index,
    input  logic signed [15:0] i_book_value,
    input  logic [7:0]         i_data_byte,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_pcm_sample,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import vsd_pkg::*;

    t_cfg r_cfg;
    logic cfg_wr;
    logic accept;
    logic fe_valid, q_valid, q_pop;
    t_cmd fe_cmd, q_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= 1'b0;
            r_cfg.order <= 3'd2;
            r_cfg.limit <= 24'd0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MODE:  r_cfg.mode <= pwdata[0];
                REG_ORDER: r_cfg.order <= pwdata[2:0];
                REG_LIMIT: r_cfg.limit <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODE:  prdata = {31'd0, r_cfg.mode};
            REG_ORDER: prdata = {29'd0, r_cfg.order};
            REG_LIMIT: prdata = {8'd0, r_cfg.limit};
            default:   prdata = 32'd0;
        endcase
    end

    vsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_kind),
        .i_book_index (i_book_index),
        .i_book_value (i_book_value),
        .i_data_byte  (i_data_byte),
        .i_cfg        (r_cfg),
        .o_cmd_valid  (fe_valid),
        .o_cmd        (fe_cmd)
    );

    vsd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fe_valid),
        .i_wdata (fe_cmd),
        .i_rd    (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_rdata (q_cmd)
    );

    vsd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_cmd_pop    (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_pcm_sample (o_pcm_sample),
        .o_last       (o_last)
    );
endmodule

>>> test/tb_vadpcm_sample_decoder_top.sv
// Self-checking testbench for the VADPCM sample decoder top level.
`timescale 1ns / 1ps
module tb_vadpcm_sample_decoder_top;
    import vsd_pkg::*;

    // This many codebook entries are loaded at the start, and every predictor is kept inside them.
    localparam int BOOK_USED = 128;

    typedef struct {
        logic signed [15:0] pcm;
        logic               last;
    } t_sample;

    typedef struct {
        logic [1:0]  kind;
        logic [8:0]  idx;
        logic [15:0] val;
        logic [7:0]  data;
        bit          zero_out;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         i_kind = '0;
    logic [8:0]         i_book_index = '0;
    logic signed [15:0] i_book_value = '0;
    logic [7:0]         i_data_byte = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [15:0] o_pcm_sample;
    logic               o_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    vadpcm_sample_decoder_top u_dut (.*);

    always #6 i_clk = ~i_clk;

    // Predictor state.
    logic signed [15:0] book [BOOK_ENTRIES];
    logic signed [15:0] resid [8];
    logic signed [15:0] hist_old, hist_new;
    logic [3:0]         shift_amt, pred_sel;
    int unsigned        frame_pos, emitted;
    logic               cfg_mode;
    logic [2:0]         cfg_order;
    logic [23:0]        cfg_limit;

    t_sample     pending_samples[$];
    int          mismatches = 0;
    int          samples_seen = 0;
    int          items_sent = 0;
    bit          hold_done = 1'b0;

    task automatic report(string what, longint exp_v, longint act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
    endtask

    function automatic int coef(int unsigned addr);
        return int'(book[addr % BOOK_ENTRIES]);
    endfunction

    function automatic logic signed [15:0] predict_sample(int unsigned i);
        int unsigned base;
        bit [31:0]   acc;
        int          v;
        base = int'(pred_sel) * int'(cfg_order) * 8;
        acc = 32'(coef(base + i) * int'(hist_old));
        acc = acc + 32'(coef(base + 8 + i) * int'(hist_new));
        acc = acc + (32'(int'(resid[i])) << 11);
        for (int unsigned p = 0; p < i; p++)
            acc = acc + 32'(coef(base + 8 + (i - p - 1)) * int'(resid[p]));
        v = $signed(acc) >>> 11;
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return 16'(v);
    endfunction

    task automatic decode_item(t_row r);
        int unsigned        flen, per, half_bytes, pos, first, cnt;
        int                 code;
        logic [3:0]         nib;
        logic [1:0]         crumb;
        logic signed [15:0] smp [4];
        t_sample            s;
        case (r.kind)
            KIND_LOAD: book[r.idx % BOOK_ENTRIES] = r.val;
            KIND_RESTART: begin
                hist_old = '0;
                hist_new = '0;
                shift_amt = '0;
                pred_sel = '0;
                frame_pos = 0;
                emitted = 0;
            end
            KIND_BYTE: begin
                flen = cfg_mode ? 5 : 9;
                per = cfg_mode ? 4 : 2;
                half_bytes = cfg_mode ? 2 : 4;
                if (frame_pos == 0 || frame_pos >= flen) begin
                    shift_amt = r.data[7:4];
                    pred_sel = r.data[3:0];
                    frame_pos = 1;
                end else begin
                    pos = (frame_pos - 1) % half_bytes;
                    first = pos * per;
                    for (int unsigned j = 0; j < per; j++) begin
                        if (cfg_mode) begin
                            crumb = r.data[7 - 2 * j -: 2];
                            code = int'($signed(crumb));
                        end else begin
                            nib = (j == 0) ? r.data[7:4] : r.data[3:0];
                            code = int'($signed(nib));
                        end
                        resid[first + j] = 16'(code << shift_amt);
                    end
                    for (int unsigned j = 0; j < per; j++)
                        smp[j] = predict_sample(first + j);
                    cnt = 0;
                    for (int unsigned j = 0; j < per; j++) begin
                        if (cfg_limit != 0 && emitted >= cfg_limit)
                            break;
                        s.pcm = r.zero_out ? 16'sd0 : smp[j];
                        s.last = 1'b0;
                        pending_samples = {pending_samples, s};
                        cnt++;
                        if (emitted < LIMIT_MAX)
                            emitted++;
                    end
                    if (cnt > 0)
                        pending_samples[$].last = 1'b1;
                    if (pos == half_bytes - 1) begin
                        hist_old = smp[per - 2];
                        hist_new = smp[per - 1];
                    end
                    frame_pos++;
                    if (frame_pos >= flen)
                        frame_pos = 0;
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [3:0] legal_pred(logic [3:0] p);
        int unsigned lim;
        lim = (cfg_order == 3'd0) ? 15 : 14 / int'(cfg_order);
        return (p <= lim) ? p : 4'(p % (lim + 1));
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;

    task automatic send_item(t_row r);
        int gap;
        if (r.kind == KIND_BYTE && (frame_pos == 0 || frame_pos >= (cfg_mode ? 5 : 9)))
            r.data[3:0] = legal_pred(r.data[3:0]);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (push && gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_kind <= r.kind;
        i_book_index <= r.idx;
        i_book_value <= r.val;
        i_data_byte <= r.data;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        decode_item(r);
        items_sent++;
        burst_left--;
    endtask

    task automatic apb_access(logic wr, logic [1:0] reg_idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {reg_idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_pipeline();
        push <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_samples.size() != 0);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic configure(logic mode, logic [2:0] order, logic [23:0] limit);
        logic [31:0] rd;
        apb_access(1'b1, REG_MODE, 32'(mode), rd);
        apb_access(1'b1, REG_ORDER, 32'(order), rd);
        apb_access(1'b1, REG_LIMIT, 32'(limit), rd);
        cfg_mode = mode;
        cfg_order = order;
        cfg_limit = limit;
        apb_access(1'b0, REG_MODE, '0, rd);
        if (rd[0] !== mode) report("codec_mode readback", mode, rd[0]);
        apb_access(1'b0, REG_ORDER, '0, rd);
        if (rd[2:0] !== order) report("book_order readback", order, rd[2:0]);
        apb_access(1'b0, REG_LIMIT, '0, rd);
        if (rd[23:0] !== limit) report("sample_limit readback", limit, rd[23:0]);
    endtask

    function automatic t_row mk(logic [1:0] k, logic [8:0] ix, logic [15:0] v,
                                logic [7:0] d, bit z);
        t_row r;
        r.kind = k;
        r.idx = ix;
        r.val = v;
        r.data = d;
        r.zero_out = z;
        return r;
    endfunction

    function automatic logic [15:0] rand_coef();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 4095) - 2048);
    endfunction

    task automatic send_frame(int broken);
        int unsigned flen;
        flen = cfg_mode ? 5 : 9;
        send_item(mk(KIND_BYTE, '0, '0, 8'($urandom), 1'b0));
        for (int unsigned b = 1; b < flen - broken; b++)
            send_item(mk(KIND_BYTE, 9'($urandom), 16'($urandom), 8'($urandom), 1'b0));
    endtask

    // Receiver: a rotating stall pattern plus one long hold-off.
    initial begin
        logic [7:0] mask;
        int         tick;
        int         hold;
        mask = 8'hFF;
        tick = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (pending_samples.size() == 0) begin
                    report("unexpected sample", 0, o_pcm_sample);
                end else begin
                    if (o_pcm_sample !== pending_samples[0].pcm)
                        report("pcm_sample", pending_samples[0].pcm, o_pcm_sample);
                    if (o_last !== pending_samples[0].last)
                        report("last", pending_samples[0].last, o_last);
                    void'(pending_samples.pop_front());
                end
                samples_seen++;
                if (samples_seen == 40 && !hold_done) begin
                    hold = 300;
                    hold_done = 1'b1;
                end
            end
            tick++;
            if (tick % 64 == 0)
                mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
            mask = {mask[0], mask[7:1]};
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else begin
                pop <= mask[0] | (mask == 8'h00);
            end
        end
    end

    initial begin
        #(12 * 4_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        t_row rows [$];
        int   sel;
        logic [2:0]  ph_order [8];
        logic        ph_mode  [8];
        logic [23:0] ph_limit [8];
        ph_order = '{3'd2, 3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd6};
        ph_mode = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        ph_limit = '{24'd0, 24'd0, 24'hFFFFFF, 24'd7, 24'd3, 24'd0, 24'd40, 24'd1};
        foreach (book[i]) book[i] = '0;
        foreach (resid[i]) resid[i] = '0;
        hist_old = '0;
        hist_new = '0;
        shift_amt = '0;
        pred_sel = '0;
        frame_pos = 0;
        emitted = 0;
        cfg_mode = 1'b0;
        cfg_order = 3'd2;
        cfg_limit = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < BOOK_USED; i++)
            send_item(mk(KIND_LOAD, 9'(i), rand_coef(), 8'($urandom), 1'b0));

        // A zero half-frame from a cleared history decodes to silence.
        rows = {rows, mk(KIND_RESTART, 9'h1FF, 16'hFFFF, 8'hFF, 1'b0)};
        rows = {rows, mk(KIND_BYTE, '0, '0, 8'h00, 1'b0)};
        repeat (4) rows = {rows, mk(KIND_BYTE, '0, '0, 8'h00, 1'b1)};
        rows = {rows, mk(KIND_BYTE, '0, '0, 8'h7F, 1'b0)};
        rows = {rows, mk(KIND_BYTE, '0, '0, 8'h80, 1'b0)};
        rows = {rows, mk(KIND_BYTE, '0, '0, 8'hF7, 1'b0)};
        rows = {rows, mk(KIND_BYTE, '0, '0, 8'h08, 1'b0)};
        rows = {rows, mk(KIND_BYTE, '0, '0, 8'hFF, 1'b0)};
        rows = {rows, mk(KIND_BYTE, '0, '0, 8'h88, 1'b0)};
        rows = {rows, mk(2'd3, 9'h1FF, 16'hFFFF, 8'hFF, 1'b0)};
        rows = {rows, mk(KIND_BYTE, '0, '0, 8'h77, 1'b0)};
        rows = {rows, mk(KIND_LOAD, 9'h1FF, 16'h8000, 8'h00, 1'b0)};
        rows = {rows, mk(KIND_LOAD, 9'h000, 16'h7FFF, 8'h00, 1'b0)};
        rows = {rows, mk(KIND_BYTE, '0, '0, 8'h0F, 1'b0)};
        rows = {rows, mk(KIND_BYTE, '0, '0, 8'hF0, 1'b0)};
        rows = {rows, mk(KIND_BYTE, '0, '0, 8'h3C, 1'b0)};
        rows = {rows, mk(KIND_BYTE, '0, '0, 8'h81, 1'b0)};
        rows = {rows, mk(KIND_BYTE, '0, '0, 8'h7E, 1'b0)};
        foreach (rows[i]) send_item(rows[i]);

        for (int ph = 0; ph < 8; ph++) begin
            drain_pipeline();
            configure(ph_mode[ph], ph_order[ph], ph_limit[ph]);
            if (ph % 3 == 0)
                send_item(mk(KIND_RESTART, 9'($urandom), 16'($urandom), 8'($urandom), 1'b0));
            for (int n = 0; n < 32; ) begin
                sel = $urandom_range(0, 19);
                if (sel < 14) begin
                    send_frame(0);
                    n += cfg_mode ? 5 : 9;
                end else if (sel < 16) begin
                    send_frame($urandom_range(1, 3));
                    n += 2;
                end else if (sel == 16) begin
                    send_item(mk(KIND_RESTART, 9'($urandom), 16'($urandom),
                                 8'($urandom), 1'b0));
                end else if (sel == 17) begin
                    send_item(mk(KIND_LOAD, 9'($urandom), rand_coef(), 8'($urandom), 1'b0));
                end else if (sel == 18) begin
                    send_item(mk(2'd3, 9'($urandom), 16'($urandom), 8'($urandom), 1'b0));
                end else begin
                    send_item(mk(KIND_BYTE, 9'($urandom), 16'($urandom), 8'($urandom), 1'b0));
                    n++;
                end
            end
        end
        drain_pipeline();

        $display("Run covered %0d input items and %0d decoded samples over 8 register settings,",
                 items_sent, samples_seen);
        $display("both codec modes, orders 0 to 7, several sample limits and a long output stall.");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches in total.", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
